[src/assert_macros.svh]
// Assertion macros shared by the Morse decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

[src/mcd_pkg.sv]
// Morse decoder package: sizes, symbol codes, job word type and the code table.
// No dependencies; used by every mcd_* module and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mcd_pkg;

   localparam int MaxSymbols   = 6;
   localparam int LenWidth     = $clog2(MaxSymbols + 1);
   localparam int RunWidth     = 2;
   localparam int SpaceRunMax  = 3;

   localparam logic [7:0] SymDot   = 8'd46;
   localparam logic [7:0] SymDash  = 8'd45;
   localparam logic [7:0] SymSpace = 8'd32;

   localparam logic [6:0] CharGap  = 7'd32;
   localparam logic [6:0] CharNone = 7'd0;

   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // One unit of work handed from the front end to the back end.
   typedef struct packed {
      logic                  letter;      // a gathered code is finished
      logic                  gap;         // a word space goes ahead of it
      logic [MaxSymbols-1:0] code_bits;
      logic [LenWidth-1:0]   code_length;
      logic                  overflow;
      logic                  last;        // final result of the message
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Table entry: {length[2:0], pattern[5:0] (dash = 1, first symbol MSB), ascii[6:0]}
   localparam int TableSize = 39;
   localparam logic [15:0] CodeRom [TableSize] = '{
      {3'd2, 6'b000001, 7'd65}, {3'd4, 6'b001000, 7'd66}, {3'd4, 6'b001010, 7'd67},
      {3'd3, 6'b000100, 7'd68}, {3'd1, 6'b000000, 7'd69}, {3'd4, 6'b000010, 7'd70},
      {3'd3, 6'b000110, 7'd71}, {3'd4, 6'b000000, 7'd72}, {3'd2, 6'b000000, 7'd73},
      {3'd4, 6'b000111, 7'd74}, {3'd3, 6'b000101, 7'd75}, {3'd4, 6'b000100, 7'd76},
      {3'd2, 6'b000011, 7'd77}, {3'd2, 6'b000010, 7'd78}, {3'd3, 6'b000111, 7'd79},
      {3'd4, 6'b000110, 7'd80}, {3'd4, 6'b001101, 7'd81}, {3'd3, 6'b000010, 7'd82},
      {3'd3, 6'b000000, 7'd83}, {3'd1, 6'b000001, 7'd84}, {3'd3, 6'b000001, 7'd85},
      {3'd4, 6'b000001, 7'd86}, {3'd3, 6'b000011, 7'd87}, {3'd4, 6'b001001, 7'd88},
      {3'd4, 6'b001011, 7'd89}, {3'd4, 6'b001100, 7'd90},
      {3'd5, 6'b001111, 7'd49}, {3'd5, 6'b000111, 7'd50}, {3'd5, 6'b000011, 7'd51},
      {3'd5, 6'b000001, 7'd52}, {3'd5, 6'b000000, 7'd53}, {3'd5, 6'b010000, 7'd54},
      {3'd5, 6'b011000, 7'd55}, {3'd5, 6'b011100, 7'd56}, {3'd5, 6'b011110, 7'd57},
      {3'd5, 6'b011111, 7'd48},
      {3'd6, 6'b010101, 7'd46}, {3'd6, 6'b110011, 7'd44}, {3'd6, 6'b001100, 7'd63}
   };

   // Parallel match against every table entry; codes are unique so OR is safe.
   function automatic logic [6:0] lookup_code(input logic [MaxSymbols-1:0] bits,
                                              input logic [LenWidth-1:0]   len);
      logic [6:0]  ch;
      logic [15:0] entry;
      ch = CharNone;
      for (int i = 0; i < TableSize; i++) begin
         entry = CodeRom[i];
         if (len == LenWidth'(entry[15:13]) && bits == MaxSymbols'(entry[12:7])) begin
            ch = ch | entry[6:0];
         end
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

[src/morse_code_decoder.sv]
// Morse code decoder top level: joins front end, job queue and back end.
// Depends on mcd_pkg, mcd_front, mcd_queue and mcd_back.
//
// Usage:
//  - Input channel (req_*): one word per cycle, a byte of Morse text ('.', '-', ' ')
//    plus a message-end flag. Taken at a clock edge with req_push high and
//    req_full low. Other bytes are taken and ignored.
//  - Result channel (rsp_*): one decoded character, word space or flag word per
//    pop. rsp_empty low means the word on rsp_* is valid; it is taken at a clock
//    edge with rsp_pop high.
//  - Path: a result reaches rsp_* through the job queue and then the output
//    register of the back end. A letter after a word gap gives two words, the
//    space first.
//  - Throughput: one input word per cycle while req_full is low; output is one word
//    per cycle while rsp_pop is high, set by the single output register of the back end.
//  - Stall: while rsp_pop is low, up to four jobs collect in the queue; after
//    that req_full rises until the receiver drains it.
//  - Reset (reset, synchronous, active high): clears the gathered code, the
//    space run, the queue and the output valid flag; the first word can be
//    pushed on the cycle after reset falls.
`timescale 1ns / 1ps
`default_nettype none

module morse_code_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_symbol,
   input  wire logic       req_message_end,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [6:0]      rsp_character,
   output logic            rsp_has_character,
   output logic            rsp_unknown_code,
   output logic            rsp_last_of_message
);

   // job words from the front end to the queue
   logic                      job_push;
   mcd_pkg::job_type          job;
   // head of queue towards the back end
   mcd_pkg::job_type          head;
   mcd_pkg::queue_status_type q_status;
   logic                      q_pop;

   // Front end: symbol gathering, space run and word-gap tracking.
   mcd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_push        (req_push),
      .in_symbol      (req_symbol),
      .in_message_end (req_message_end),
      .q_status       (q_status),
      .in_full        (req_full),
      .job_push       (job_push),
      .job            (job)
   );

   // Decoupling queue: lets the front keep taking words while the result side stalls.
   mcd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (q_pop),
      .head     (head),
      .status   (q_status)
   );

   // Back end: table lookup and result output register.
   mcd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .q_status            (q_status),
      .q_pop               (q_pop),
      .out_pop             (rsp_pop),
      .out_empty           (rsp_empty),
      .out_character       (rsp_character),
      .out_has_character   (rsp_has_character),
      .out_unknown_code    (rsp_unknown_code),
      .out_last_of_message (rsp_last_of_message)
   );

endmodule

`default_nettype wire

[src/mcd_front.sv]
// Front end: takes input words, tracks the code being gathered and the space run,
// and issues job words. Depends on mcd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mcd_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_push,
   input  wire logic [7:0]                in_symbol,
   input  wire logic                      in_message_end,
   input  wire mcd_pkg::queue_status_type q_status,
   output logic                           in_full,
   output logic                           job_push,
   output mcd_pkg::job_type               job
);

   logic [mcd_pkg::MaxSymbols-1:0] code_bits_ff,   code_bits_in;
   logic [mcd_pkg::LenWidth-1:0]   code_length_ff, code_length_in;
   logic                           code_overflow_ff, code_overflow_in;
   logic [mcd_pkg::RunWidth-1:0]   space_run_ff,   space_run_in;
   logic                           gap_pending_ff, gap_pending_in;
   logic                           letter_seen_ff, letter_seen_in;

   logic                           accept;
   logic                           is_dash, is_mark, is_space, pending;
   logic [mcd_pkg::MaxSymbols-1:0] next_bits;
   logic [mcd_pkg::LenWidth-1:0]   next_len;
   logic                           next_ovf;
   logic [mcd_pkg::RunWidth-1:0]   run_next;
   logic                           finish;

   assign in_full = q_status.full;
   assign accept  = in_push && !q_status.full;

   always_comb begin
      is_dash  = (in_symbol == mcd_pkg::SymDash);
      is_mark  = is_dash || (in_symbol == mcd_pkg::SymDot);
      is_space = (in_symbol == mcd_pkg::SymSpace);
      pending  = (code_length_ff != '0) || code_overflow_ff;

      next_bits = code_bits_ff;
      next_len  = code_length_ff;
      next_ovf  = code_overflow_ff;
      if (is_mark) begin
         if (code_length_ff < mcd_pkg::LenWidth'(mcd_pkg::MaxSymbols)) begin
            next_bits = {code_bits_ff[mcd_pkg::MaxSymbols-2:0], is_dash};
            next_len  = code_length_ff + mcd_pkg::LenWidth'(1);
         end else begin
            next_ovf = 1'b1;
         end
      end

      run_next = space_run_ff;
      if (space_run_ff < mcd_pkg::RunWidth'(mcd_pkg::SpaceRunMax)) begin
         run_next = space_run_ff + mcd_pkg::RunWidth'(1);
      end

      // a space ends a pending code; the message end flushes whatever is left
      finish = (is_space && pending) ||
               (in_message_end && (is_mark || (!is_space && pending)));

      job.letter      = finish;
      job.gap         = finish && gap_pending_ff && letter_seen_ff;
      job.code_bits   = next_bits;
      job.code_length = next_len;
      job.overflow    = next_ovf;
      job.last        = in_message_end;
      job_push        = accept && (finish || in_message_end);

      code_bits_in     = next_bits;
      code_length_in   = next_len;
      code_overflow_in = next_ovf;
      space_run_in     = space_run_ff;
      gap_pending_in   = gap_pending_ff;
      letter_seen_in   = letter_seen_ff;

      if (is_mark) begin
         space_run_in = '0;
      end else if (is_space) begin
         if (pending) begin
            space_run_in = mcd_pkg::RunWidth'(1);
         end else begin
            space_run_in = run_next;
            if (run_next == mcd_pkg::RunWidth'(mcd_pkg::SpaceRunMax) && letter_seen_ff) begin
               gap_pending_in = 1'b1;
            end
         end
      end

      if (finish) begin
         code_bits_in     = '0;
         code_length_in   = '0;
         code_overflow_in = 1'b0;
         gap_pending_in   = 1'b0;
         letter_seen_in   = 1'b1;
      end

      if (in_message_end) begin
         code_bits_in     = '0;
         code_length_in   = '0;
         code_overflow_in = 1'b0;
         space_run_in     = '0;
         gap_pending_in   = 1'b0;
         letter_seen_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_bits_ff     <= '0;
         code_length_ff   <= '0;
         code_overflow_ff <= 1'b0;
         space_run_ff     <= '0;
         gap_pending_ff   <= 1'b0;
         letter_seen_ff   <= 1'b0;
      end else if (accept) begin
         code_bits_ff     <= code_bits_in;
         code_length_ff   <= code_length_in;
         code_overflow_ff <= code_overflow_in;
         space_run_ff     <= space_run_in;
         gap_pending_ff   <= gap_pending_in;
         letter_seen_ff   <= letter_seen_in;
      end
   end

   `ASSERT_IMPLIES(a_letter_has_code, clock, reset, job_push && job.letter, job.code_length != '0 || job.overflow)
   `ASSERT_IMPLIES(a_gap_needs_letter, clock, reset, job_push && job.gap, job.letter)
   `ASSERT_IMPLIES(a_gap_after_letter, clock, reset, gap_pending_ff, letter_seen_ff)

endmodule

`default_nettype wire

[src/mcd_queue.sv]
// Short job queue between the front end and the back end.
// Depends on mcd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mcd_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire mcd_pkg::job_type          push_job,
   input  wire logic                      pop,
   output mcd_pkg::job_type               head,
   output mcd_pkg::queue_status_type      status
);

   mcd_pkg::job_type                    jobs_ff [mcd_pkg::QueueDepth];
   logic [mcd_pkg::QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [mcd_pkg::QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [mcd_pkg::QueueCntWidth-1:0]   count_ff,  count_in;

   assign head         = jobs_ff[rd_ptr_ff];
   assign status.full  = (count_ff == mcd_pkg::QueueCntWidth'(mcd_pkg::QueueDepth));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + mcd_pkg::QueuePtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + mcd_pkg::QueuePtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + mcd_pkg::QueueCntWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - mcd_pkg::QueueCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         jobs_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push, !status.full || pop)
   `ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, pop, !status.empty)

endmodule

`default_nettype wire

[src/mcd_back.sv]
// Back end: looks up finished codes, splits a job into its word-space and
// letter results, and holds the output register. Depends on mcd_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mcd_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mcd_pkg::job_type          head,
   input  wire mcd_pkg::queue_status_type q_status,
   output logic                           q_pop,
   input  wire logic                      out_pop,
   output logic                           out_empty,
   output logic [6:0]                     out_character,
   output logic                           out_has_character,
   output logic                           out_unknown_code,
   output logic                           out_last_of_message
);

   logic       out_valid_ff, out_valid_in;
   logic       phase_ff,     phase_in;
   logic [6:0] char_ff,      char_in;
   logic       has_ff,       has_in;
   logic       unk_ff,       unk_in;
   logic       last_ff,      last_in;

   logic       load, take, emit_gap;
   logic [6:0] letter_ch;

   always_comb begin
      load      = !out_valid_ff || out_pop;
      take      = load && !q_status.empty;
      emit_gap  = head.gap && !phase_ff;
      q_pop     = take && !emit_gap;
      letter_ch = head.overflow ? mcd_pkg::CharNone
                                : mcd_pkg::lookup_code(head.code_bits, head.code_length);

      phase_in     = take ? emit_gap : phase_ff;
      out_valid_in = take ? 1'b1 : (out_pop ? 1'b0 : out_valid_ff);

      if (emit_gap) begin
         char_in = mcd_pkg::CharGap;
         has_in  = 1'b1;
         unk_in  = 1'b0;
         last_in = 1'b0;
      end else if (head.letter) begin
         char_in = letter_ch;
         has_in  = (letter_ch != mcd_pkg::CharNone);
         unk_in  = (letter_ch == mcd_pkg::CharNone);
         last_in = head.last;
      end else begin
         char_in = mcd_pkg::CharNone;
         has_in  = 1'b0;
         unk_in  = 1'b0;
         last_in = head.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= char_in;
         has_ff  <= has_in;
         unk_ff  <= unk_in;
         last_ff <= last_in;
      end
   end

   assign out_empty           = !out_valid_ff;
   assign out_character       = char_ff;
   assign out_has_character   = has_ff;
   assign out_unknown_code    = unk_ff;
   assign out_last_of_message = last_ff;

   `ASSERT_IMPLIES(a_phase_holds_job, clock, reset, phase_ff, !q_status.empty && head.gap)
   `ASSERT_NEXT(a_gap_then_letter, clock, reset, take && emit_gap, phase_ff && out_valid_ff)

endmodule

`default_nettype wire
